FILE: rtl/core/chf_pkg.sv
`timescale 1ns / 1ps
package chf_pkg;

  // stream field widths
  localparam int FIELD_BITS = 32;
  localparam int INT_BITS   = 4;

  // request kinds carried on in_tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_J_START,
    ST_K_LOOP,
    ST_D_RD,
    ST_D_WAIT,
    ST_D_CALC,
    ST_PIVOT,
    ST_UNIT,
    ST_WB,
    ST_READY,
    ST_FOUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic mem_we;
    logic wsel_unit;
    logic rd_en;
    logic mac_v;
    logic acc_clr;
    logic d_calc;
    logic start_sqrt;
    logic start_div;
    logic out_load;
    logic out_zero;
    logic out_one;
    logic out_fail;
    logic out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic d_le0;
    logic unit_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/chf_rdu.sv
`timescale 1ns / 1ps
// Shared iterative unit: floor square root of (d << F), one result bit per cycle,
// and restoring division (|d| << F) / dv, one quotient bit per cycle.
module chf_rdu
  import chf_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_sqrt,
  input  logic                         start_div,
  input  logic signed [VALUE_BITS-1:0] d_val,
  input  logic        [VALUE_BITS-1:0] dv,
  output logic signed [VALUE_BITS-1:0] result,
  output logic                         done
);

  localparam int VB   = VALUE_BITS;
  localparam int F    = VB - INT_BITS;
  localparam int W2   = 2 * VB;
  localparam int CNTW = $clog2(W2 + 1);
  localparam logic [W2-1:0] QMAX = W2'((65'(1) << (VB - 1)) - 65'(1));
  localparam logic [W2-1:0] QLIM = W2'(65'(1) << (VB - 1));

  logic            busy_r, sqrt_r, neg_r, done_r;
  logic [CNTW-1:0] cnt_r;
  logic [W2-1:0]   num_r, q_r;
  logic [VB+1:0]   rem_r;
  logic [VB-1:0]   dv_r;
  logic [VB-1:0]   d_mag;
  logic [VB+1:0]   r_sq, t_sq, r_dv, t_dv;

  assign d_mag = d_val[VB-1] ? VB'(-d_val) : VB'(d_val);

  // one digit of each recurrence
  assign r_sq = {rem_r[VB-1:0], num_r[W2-1 -: 2]};
  assign t_sq = {q_r[VB-1:0], 2'b01};
  assign r_dv = {rem_r[VB:0], num_r[W2-1]};
  assign t_dv = {2'b00, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start_sqrt || start_div) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNTW'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_sqrt || start_div) begin
      sqrt_r <= start_sqrt;
      neg_r  <= d_val[VB-1];
      dv_r   <= dv;
      num_r  <= W2'(d_mag) << F;
      q_r    <= '0;
      rem_r  <= '0;
      cnt_r  <= start_sqrt ? CNTW'(VB) : CNTW'(W2);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (sqrt_r) begin
        num_r <= num_r << 2;
        if (r_sq >= t_sq) begin
          rem_r <= r_sq - t_sq;
          q_r   <= {q_r[W2-2:0], 1'b1};
        end else begin
          rem_r <= r_sq;
          q_r   <= {q_r[W2-2:0], 1'b0};
        end
      end else begin
        num_r <= num_r << 1;
        if (r_dv >= t_dv) begin
          rem_r <= r_dv - t_dv;
          q_r   <= {q_r[W2-2:0], 1'b1};
        end else begin
          rem_r <= r_dv;
          q_r   <= {q_r[W2-2:0], 1'b0};
        end
      end
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    if (sqrt_r) begin
      result = VB'(q_r);
    end else if (neg_r) begin
      result = (q_r >= QLIM) ? VB'(QLIM) : VB'(-q_r);
    end else begin
      result = (q_r > QMAX) ? VB'(QMAX) : VB'(q_r);
    end
  end

  assign done = done_r;

endmodule

FILE: rtl/core/chf_dp.sv
`timescale 1ns / 1ps
module chf_dp
  import chf_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int DEPTH      = 2304,
  parameter int AW         = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [AW-1:0]         waddr,
  input  logic [AW-1:0]         raddr_a,
  input  logic [AW-1:0]         raddr_b,
  input  logic [FIELD_BITS-1:0] in_data,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [FIELD_BITS-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int VB = VALUE_BITS;
  localparam int F  = VB - INT_BITS;
  localparam logic signed [64:0] VMAX_W = (65'(1) <<< (VB - 1)) - 65'(1);
  localparam logic signed [64:0] VMIN_W = -VMAX_W - 65'(1);
  localparam logic signed [VB:0] VMAX_E = (VB+1)'(VMAX_W);
  localparam logic signed [VB:0] VMIN_E = (VB+1)'(VMIN_W);
  localparam logic signed [2*VB-1:0] VMAX_P = (2*VB)'(VMAX_W);
  localparam logic signed [2*VB-1:0] VMIN_P = (2*VB)'(VMIN_W);
  localparam logic signed [VB-1:0] ONE = VB'(65'(1) <<< F);

  logic signed [VB-1:0]   mem [DEPTH];
  logic signed [VB-1:0]   rd_a_r, rd_b_r, acc_r, d_r, unit_res, wdata, lval, prod_s;
  logic signed [2*VB-1:0] prod_r, prod_t;
  logic signed [VB:0]     sum_e, dif_e;
  logic signed [64:0]     ev;
  logic [VB-1:0]          dv_r;
  logic                   v1_r, pv_r, unit_done;
  logic                   out_valid_r, out_last_r, out_fail_r;
  logic [FIELD_BITS-1:0]  out_data_r;
  logic signed [VB-1:0]   out_val;

  // load value: sign-extend and saturate to the value range
  assign ev   = 65'(signed'(in_data));
  assign lval = (ev > VMAX_W) ? VB'(VMAX_W) : (ev < VMIN_W) ? VB'(VMIN_W) : VB'(ev);
  assign wdata = cmd.wsel_unit ? unit_res : lval;

  // matrix store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  // product truncated toward zero, then saturated
  assign prod_t = prod_r[2*VB-1] ? -((-prod_r) >>> F) : (prod_r >>> F);
  assign prod_s = (prod_t > VMAX_P) ? VB'(VMAX_P) : (prod_t < VMIN_P) ? VB'(VMIN_P)
                                                                      : VB'(prod_t);
  assign sum_e = (VB+1)'(acc_r) + (VB+1)'(prod_s);
  assign dif_e = (VB+1)'(rd_a_r) - (VB+1)'(acc_r);

  // multiply-accumulate pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_v;
      pv_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= rd_a_r * rd_b_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= (sum_e > VMAX_E) ? VB'(VMAX_E) : (sum_e < VMIN_E) ? VB'(VMIN_E) : VB'(sum_e);
    end
    if (cmd.d_calc) begin
      d_r  <= (dif_e > VMAX_E) ? VB'(VMAX_E) : (dif_e < VMIN_E) ? VB'(VMIN_E) : VB'(dif_e);
      dv_r <= rd_b_r[VB-1] ? VB'(-rd_b_r) : VB'(rd_b_r);
    end
  end

  chf_rdu #(.VALUE_BITS(VB)) u_rdu (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_sqrt (cmd.start_sqrt),
    .start_div  (cmd.start_div),
    .d_val      (d_r),
    .dv         (dv_r),
    .result     (unit_res),
    .done       (unit_done)
  );

  // output register
  assign out_val = cmd.out_one ? ONE : cmd.out_zero ? '0 : rd_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= FIELD_BITS'(out_val);
      out_fail_r <= cmd.out_fail;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_fail_r;
  assign out_tlast     = out_last_r;
  assign sts.d_le0     = d_r[VB-1] || (d_r == '0);
  assign sts.unit_done = unit_done;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

FILE: rtl/core/chf_ctrl.sv
`timescale 1ns / 1ps
module chf_ctrl
  import chf_pkg::*;
#(
  parameter int MAX_DIM = 48,
  parameter int AW      = 12,
  parameter int DW      = 6,
  parameter int CW      = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_kind,
  input  logic          cfg_wr_en,
  input  logic [5:0]    cfg_wr_data,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [AW-1:0] waddr,
  output logic [AW-1:0] raddr_a,
  output logic [AW-1:0] raddr_b
);

  localparam int DIM_RST = (48 > MAX_DIM) ? MAX_DIM : 48;

  state_t        state_r, state_nxt;
  logic [DW-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DW-1:0] fi_r, fi_nxt, fj_r, fj_nxt, cfg_n;
  logic [CW-1:0] total_r, total_nxt, ld_r, ld_nxt;
  logic [AW-1:0] fcnt_r, fcnt_nxt, bi_r, bi_nxt, bj_r, bj_nxt;
  logic          fail_r, fail_nxt, in_fire;
  logic [6:0]    cfg_w;

  assign in_fire = in_tvalid && in_tready;
  assign cfg_w   = {1'b0, cfg_wr_data};
  assign cfg_n   = (cfg_w == 7'd0) ? DW'(1) : (cfg_w > 7'(MAX_DIM)) ? DW'(MAX_DIM)
                                                                    : DW'(cfg_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      n_r     <= DW'(DIM_RST);
      total_r <= CW'(DIM_RST * DIM_RST);
      ld_r    <= '0;
      fcnt_r  <= '0;
      fi_r    <= '0;
      fj_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      bi_r    <= '0;
      bj_r    <= '0;
      fail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      total_r <= total_nxt;
      ld_r    <= ld_nxt;
      fcnt_r  <= fcnt_nxt;
      fi_r    <= fi_nxt;
      fj_r    <= fj_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      bi_r    <= bi_nxt;
      bj_r    <= bj_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    total_nxt = total_r;
    ld_nxt    = ld_r;
    fcnt_nxt  = fcnt_r;
    fi_nxt    = fi_r;
    fj_nxt    = fj_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    bi_nxt    = bi_r;
    bj_nxt    = bj_r;
    fail_nxt  = fail_r;
    cmd       = '0;
    cmd.out_fail = fail_r;
    in_tready = 1'b0;
    waddr     = AW'(ld_r);
    raddr_a   = '0;
    raddr_b   = '0;

    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_fire && (in_kind == REQ_LOAD)) begin
          cmd.mem_we = 1'b1;
          if (ld_r == '0) begin
            fail_nxt = 1'b0;
          end
          if (ld_r + CW'(1) >= total_r) begin
            ld_nxt    = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            bi_nxt    = '0;
            bj_nxt    = '0;
            state_nxt = ST_J_START;
          end else begin
            ld_nxt = ld_r + CW'(1);
          end
        end
      end

      ST_J_START: begin
        cmd.acc_clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = (j_r == '0) ? ST_D_RD : ST_K_LOOP;
      end

      // one product issued per cycle
      ST_K_LOOP: begin
        cmd.rd_en = 1'b1;
        cmd.mac_v = 1'b1;
        raddr_a   = bi_r + AW'(k_r);
        raddr_b   = bj_r + AW'(k_r);
        k_nxt     = k_r + DW'(1);
        if (k_r + DW'(1) == j_r) begin
          state_nxt = ST_D_RD;
        end
      end

      ST_D_RD: begin
        cmd.rd_en = 1'b1;
        raddr_a   = bi_r + AW'(j_r);
        raddr_b   = bj_r + AW'(j_r);
        state_nxt = ST_D_WAIT;
      end

      ST_D_WAIT: begin
        state_nxt = ST_D_CALC;
      end

      ST_D_CALC: begin
        cmd.d_calc = 1'b1;
        state_nxt  = ST_PIVOT;
      end

      ST_PIVOT: begin
        if (i_r == j_r) begin
          if (sts.d_le0) begin
            fail_nxt  = 1'b1;
            fcnt_nxt  = '0;
            fi_nxt    = '0;
            fj_nxt    = '0;
            state_nxt = ST_READY;
          end else begin
            cmd.start_sqrt = 1'b1;
            state_nxt      = ST_UNIT;
          end
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_UNIT;
        end
      end

      ST_UNIT: begin
        if (sts.unit_done) begin
          state_nxt = ST_WB;
        end
      end

      // write L[i][j] back and step to the next element
      ST_WB: begin
        cmd.mem_we    = 1'b1;
        cmd.wsel_unit = 1'b1;
        waddr         = bi_r + AW'(j_r);
        if (j_r < i_r) begin
          j_nxt     = j_r + DW'(1);
          bj_nxt    = bj_r + AW'(n_r);
          state_nxt = ST_J_START;
        end else if (i_r + DW'(1) < n_r) begin
          i_nxt     = i_r + DW'(1);
          bi_nxt    = bi_r + AW'(n_r);
          j_nxt     = '0;
          bj_nxt    = '0;
          state_nxt = ST_J_START;
        end else begin
          fcnt_nxt  = '0;
          fi_nxt    = '0;
          fj_nxt    = '0;
          state_nxt = ST_READY;
        end
      end

      ST_READY: begin
        in_tready = sts.out_free;
        if (in_fire) begin
          if (in_kind == REQ_LOAD) begin
            cmd.mem_we = 1'b1;
            waddr      = '0;
            fail_nxt   = 1'b0;
            if (total_r == CW'(1)) begin
              ld_nxt    = '0;
              i_nxt     = '0;
              j_nxt     = '0;
              bi_nxt    = '0;
              bj_nxt    = '0;
              state_nxt = ST_J_START;
            end else begin
              ld_nxt    = CW'(1);
              state_nxt = ST_LOAD;
            end
          end else begin
            cmd.rd_en = 1'b1;
            raddr_a   = fcnt_r;
            state_nxt = ST_FOUT;
          end
        end
      end

      ST_FOUT: begin
        cmd.out_load = 1'b1;
        cmd.out_zero = (fj_r > fi_r) || (fail_r && (fi_r != fj_r));
        cmd.out_one  = fail_r && (fi_r == fj_r);
        cmd.out_last = (CW'(fcnt_r) + CW'(1) == total_r);
        if (cmd.out_last) begin
          fcnt_nxt  = '0;
          ld_nxt    = '0;
          state_nxt = ST_LOAD;
        end else begin
          fcnt_nxt  = fcnt_r + AW'(1);
          state_nxt = ST_READY;
          if (fj_r + DW'(1) == n_r) begin
            fj_nxt = '0;
            fi_nxt = fi_r + DW'(1);
          end else begin
            fj_nxt = fj_r + DW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // dimension write restarts the block
    if (cfg_wr_en) begin
      n_nxt     = cfg_n;
      total_nxt = CW'(cfg_n) * CW'(cfg_n);
      ld_nxt    = '0;
      fcnt_nxt  = '0;
      fi_nxt    = '0;
      fj_nxt    = '0;
      fail_nxt  = 1'b0;
      state_nxt = ST_LOAD;
    end
  end

`ifndef SYNTHESIS
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K_LOOP) |-> (k_r < j_r))
    else $error("inner index ran past column");

  a_fetch_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READY && in_fire && in_kind == REQ_FETCH && !cfg_wr_en)
      |=> (state_r == ST_FOUT))
    else $error("fetch did not reach output stage");

  a_done_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
    sts.unit_done |-> (state_r == ST_UNIT))
    else $error("unit finished outside wait state");

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD && state_r != ST_READY) |-> !in_tready)
    else $error("request taken while factoring");
`endif

endmodule

FILE: rtl/core/cholesky_factor_with_fallback.sv
`timescale 1ns / 1ps
// Cholesky factorization with identity fallback, signed Q3.28 fixed point.
// Load requests (in_tuser = 0) take the n x n matrix row-major, one element per
// cycle. After the last element the block drops in_tready and factors the lower
// triangle in place: each element L[i][j] takes j multiply-accumulate steps (one
// product per cycle through the two read ports of the store), the states D_RD,
// D_WAIT, D_CALC and PIVOT, then a square root on the diagonal or a division off
// it in the bit-serial root/divide unit, which sets the total, and a write-back.
// Fetch requests (in_tuser = 1) then return L row-major, upper entries zero, one
// result per fetch, a new fetch being taken only once the output register is
// free; out_tuser flags a non-positive pivot, in which case the identity is
// returned. out_tlast marks the final element. A write of cfg_wr_data sets n
// (0 reads as 1, values above MAX_DIM as MAX_DIM) and restarts the block.
module cholesky_factor_with_fallback
  import chf_pkg::*;
#(
  parameter int MAX_DIM    = 48,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [FIELD_BITS-1:0] in_tdata,   // [31:0] elem_value
  input  logic                  in_tuser,   // [0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [FIELD_BITS-1:0] out_tdata,  // [31:0] factor_value
  output logic                  out_tuser,  // [0] not_pos_def
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [5:0]            cfg_wr_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] waddr, raddr_a, raddr_b;

  chf_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW),
    .DW      (DW),
    .CW      (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_kind     (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd),
    .waddr       (waddr),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b)
  );

  chf_dp #(
    .VALUE_BITS (VALUE_BITS),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .waddr      (waddr),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .in_data    (in_tdata),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/chf_checker.sv
`timescale 1ns / 1ps
module chf_checker
  import chf_pkg::*;
#(
  parameter int MAX_DIM = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [FIELD_BITS-1:0] in_tdata,   // [31:0] elem_value
  input  logic                  in_tuser,   // [0] req_type
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [FIELD_BITS-1:0] out_tdata,  // [31:0] factor_value
  input  logic                  out_tuser,  // [0] not_pos_def
  input  logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [5:0]            cfg_wr_data,
  output int                    errors,
  output int                    outstanding
);

  localparam int FRAC = FIELD_BITS - INT_BITS;
  localparam longint VMAX = (64'sd1 <<< (FIELD_BITS - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef struct {
    logic [FIELD_BITS-1:0] value;
    logic                  fail;
    logic                  last;
  } factor_elem_t;

  // shadow of the block state
  longint       mat [MAX_DIM*MAX_DIM];
  int unsigned  dim;
  int unsigned  load_cnt;
  int unsigned  fetch_cnt;
  bit           fail_seen;
  bit           ready;
  factor_elem_t factor_q[$];

  assign outstanding = factor_q.size();

  function automatic longint sat(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // product truncated toward zero
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >>> FRAC;
    return sat((p < 0) ? -m : m);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // in-place row-wise factorization, identity on a bad pivot
  task automatic factorize();
    longint s, d, q;
    longint unsigned num, dj;
    for (int unsigned i = 0; i < dim && !fail_seen; i++) begin
      for (int unsigned j = 0; j <= i; j++) begin
        s = 0;
        for (int unsigned k = 0; k < j; k++)
          s = sat(s + fx_mul(mat[i*dim+k], mat[j*dim+k]));
        d = sat(mat[i*dim+j] - s);
        if (i == j) begin
          if (d <= 0) begin
            fail_seen = 1'b1;
            break;
          end
          mat[i*dim+i] = longint'(isqrt(longint'(d) << FRAC));
        end else begin
          num = ((d < 0) ? -d : d) << FRAC;
          dj  = mat[j*dim+j] < 0 ? -mat[j*dim+j] : mat[j*dim+j];
          q   = (dj == 0) ? VMAX + 2 : longint'(num / dj);
          mat[i*dim+j] = sat((d < 0) ? -q : q);
        end
      end
    end
    if (fail_seen)
      for (int unsigned i = 0; i < dim; i++)
        for (int unsigned j = 0; j <= i; j++)
          mat[i*dim+j] = (i == j) ? (64'sd1 <<< FRAC) : 0;
  endtask

  task automatic restart();
    load_cnt  = 0;
    fetch_cnt = 0;
    fail_seen = 1'b0;
    ready     = 1'b0;
  endtask

  // one accepted input request
  task automatic predict_request(logic kind, logic [FIELD_BITS-1:0] raw);
    factor_elem_t e;
    int unsigned idx, i, j;
    if (kind == REQ_LOAD) begin
      if (ready) restart();
      if (load_cnt == 0) fail_seen = 1'b0;
      mat[load_cnt] = longint'($signed(raw));
      load_cnt++;
      if (load_cnt >= dim * dim) begin
        factorize();
        ready     = 1'b1;
        load_cnt  = 0;
        fetch_cnt = 0;
      end
    end else if (ready) begin
      idx = fetch_cnt;
      i = idx / dim;
      j = idx % dim;
      e.value = (j > i) ? '0 : mat[i*dim+j][FIELD_BITS-1:0];
      e.fail  = fail_seen;
      e.last  = (idx + 1 == dim * dim);
      factor_q.push_back(e);
      fetch_cnt++;
      if (e.last) begin
        ready     = 1'b0;
        fetch_cnt = 0;
        load_cnt  = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    factor_elem_t exp_e;
    if (!rst_n) begin
      dim = MAX_DIM;
      restart();
      factor_q.delete();
      errors <= 0;
    end else begin
      // result side
      if (out_tvalid && out_tready) begin
        if (factor_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result %h fail=%b last=%b",
                     $realtime, out_tdata, out_tuser, out_tlast);
          errors <= errors + 1;
        end else begin
          exp_e = factor_q.pop_front();
          if (out_tdata !== exp_e.value || out_tuser !== exp_e.fail ||
              out_tlast !== exp_e.last) begin
            if (errors < 10)
              $display("%0t: mismatch exp %h/%b/%b got %h/%b/%b", $realtime,
                       exp_e.value, exp_e.fail, exp_e.last,
                       out_tdata, out_tuser, out_tlast);
            errors <= errors + 1;
          end
        end
      end
      // configuration and request side
      if (cfg_wr_en) begin
        dim = (cfg_wr_data == 6'd0) ? 1 :
              (int'(cfg_wr_data) > MAX_DIM) ? MAX_DIM : int'(cfg_wr_data);
        restart();
      end else if (in_tvalid && in_tready) begin
        predict_request(in_tuser, in_tdata);
      end
    end
  end

endmodule

FILE: tb/tb_cholesky_factor_with_fallback.sv
`timescale 1ns / 1ps
module tb_cholesky_factor_with_fallback;
  import chf_pkg::*;

  localparam int MAX_DIM = 48;
  localparam int ONE     = 1 << (FIELD_BITS - INT_BITS);

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [FIELD_BITS-1:0] in_tdata;   // [31:0] elem_value
  logic                  in_tuser;   // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [FIELD_BITS-1:0] out_tdata;  // [31:0] factor_value
  logic                  out_tuser;  // [0] not_pos_def
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [5:0]            cfg_wr_data;
  int                    errors;
  int                    outstanding;

  bit  calm;
  int  cur_n;
  int  sent;
  bit  did_max;
  int  mat_buf [MAX_DIM*MAX_DIM];

  cholesky_factor_with_fallback #(.MAX_DIM(MAX_DIM), .VALUE_BITS(32)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  chf_checker #(.MAX_DIM(MAX_DIM)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result-side backpressure
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // factoring time of an n x n matrix, with margin
  function automatic int factor_cycles(int n);
    return n * n * 40 + n * n * n / 6 + 100;
  endfunction

  // one request; returns at the edge where it was taken
  task automatic push(logic kind, logic [FIELD_BITS-1:0] v);
    bit ok;
    while (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= v;
    forever begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  // dimension write once the block has drained
  task automatic set_dim(logic [5:0] raw);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (factor_cycles(cur_n)) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= raw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_n = (raw == 6'd0) ? 1 : (int'(raw) > MAX_DIM) ? MAX_DIM : int'(raw);
  endtask

  task automatic fetch_run(int cnt);
    for (int k = 0; k < cnt; k++) push(REQ_FETCH, $urandom);
  endtask

  // 0: diagonally dominant, 1: noise, 2: bad pivot, 3: saturating
  task automatic load_matrix(int kind);
    int span, off, sum, r;
    span = ONE / cur_n;
    for (int i = 0; i < cur_n; i++)
      for (int j = 0; j < i; j++) begin
        case (kind)
          1: begin
            mat_buf[i*cur_n+j] = $urandom;
            mat_buf[j*cur_n+i] = $urandom;
          end
          3: begin
            off = $urandom;
            mat_buf[i*cur_n+j] = off;
            mat_buf[j*cur_n+i] = off;
          end
          default: begin
            off = int'($urandom_range(2 * span)) - span;
            mat_buf[i*cur_n+j] = off;
            mat_buf[j*cur_n+i] = off;
          end
        endcase
      end
    for (int i = 0; i < cur_n; i++) begin
      sum = 0;
      for (int j = 0; j < cur_n; j++)
        if (j != i) sum += (mat_buf[i*cur_n+j] < 0) ? -mat_buf[i*cur_n+j] : mat_buf[i*cur_n+j];
      case (kind)
        1: mat_buf[i*cur_n+i] = $urandom;
        3: mat_buf[i*cur_n+i] = 32'h7FFF_FFFF;
        default: mat_buf[i*cur_n+i] = sum + int'($urandom_range(ONE, 1));
      endcase
    end
    if (kind == 2) begin
      r = $urandom_range(cur_n - 1);
      mat_buf[r*cur_n+r] = $urandom_range(1) ? 0 : -int'($urandom_range(ONE, 1));
    end
    for (int k = 0; k < cur_n * cur_n; k++) push(REQ_LOAD, mat_buf[k]);
    sent += cur_n * cur_n;
  endtask

  // stimulus
  initial begin
    int kind, nmat, cut;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_LOAD;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    cur_n       = MAX_DIM;
    sent        = 0;
    did_max     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fetches while loading are dropped; a partial matrix is cut by a write
    fetch_run(2);
    push(REQ_LOAD, 32'h1234_5678);
    push(REQ_LOAD, 32'hFFFF_FFFF);
    set_dim(6'd0);
    // one-element matrices: max positive, most negative, zero, one lsb
    push(REQ_LOAD, 32'h7FFF_FFFF); fetch_run(1);
    push(REQ_LOAD, 32'h8000_0000); fetch_run(1);
    push(REQ_LOAD, 32'h0000_0000); fetch_run(2);
    push(REQ_LOAD, 32'h0000_0001); fetch_run(1);
    set_dim(6'd2);
    push(REQ_LOAD, 4 * ONE); push(REQ_LOAD, 2 * ONE);
    push(REQ_LOAD, 2 * ONE); push(REQ_LOAD, 3 * ONE);
    fetch_run(2);
    // load during result readout starts over
    push(REQ_LOAD, ONE); push(REQ_LOAD, 0);
    push(REQ_LOAD, 0);   push(REQ_LOAD, -ONE);
    fetch_run(4);

    // random phases
    while (sent < 1600) begin
      if (!did_max && sent > 800) begin
        did_max = 1'b1;
        // oversized dimension writes clamp; partial matrices are dropped
        set_dim(6'd63);
        for (int k = 0; k < cur_n + 5; k++) push(REQ_LOAD, $urandom);
        sent += cur_n + 5;
        set_dim(6'd49);
        fetch_run(2);
        sent += 2;
        set_dim(6'($urandom_range(6, 2)));
      end else begin
        case ($urandom_range(19))
          0:       set_dim(6'd0);
          1:       set_dim(6'd1);
          2:       set_dim(6'($urandom_range(8, 7)));
          default: set_dim(6'($urandom_range(6, 2)));
        endcase
      end
      nmat = $urandom_range(5, 2);
      for (int m = 0; m < nmat; m++) begin
        calm = (sent > 500 && sent < 700);
        if ($urandom_range(9) == 0) fetch_run($urandom_range(3, 1));
        kind = $urandom_range(99);
        kind = (kind < 70) ? 0 : (kind < 80) ? 1 : (kind < 90) ? 2 : 3;
        load_matrix(kind);
        if ($urandom_range(99) < 85) begin
          fetch_run(cur_n * cur_n + $urandom_range(2));
          sent += cur_n * cur_n;
        end else begin
          cut = $urandom_range(cur_n * cur_n - 1);
          fetch_run(cut);
          sent += cut;
        end
      end
    end
    calm = 1'b0;

    // drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** cholesky_factor_with_fallback: PASSED **");
    end else begin
      $display("** cholesky_factor_with_fallback: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("** cholesky_factor_with_fallback: FAILED **");
    $finish;
  end

endmodule
